// ===== sv/afra_index_fragment_lookup_assert.svh =====
// Assertion macros for the fragment-index lookup block.
// Each macro expects clk and rst to be visible in the including scope.
`ifndef AFRA_INDEX_FRAGMENT_LOOKUP_ASSERT_SVH
`define AFRA_INDEX_FRAGMENT_LOOKUP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define AFRA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define AFRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/afra_pkg.sv =====
// Shared types and constants for the fragment-index lookup block.
// No dependencies; used by the result channel interface and the top level.
package afra_pkg;

  typedef enum logic [2:0] {
    ST_FOUND              = 3'd0,
    ST_NOT_FOUND          = 3'd1,
    ST_SHORT_HEADER       = 3'd2,
    ST_BAD_TAG            = 3'd3,
    ST_SIZE_MISMATCH      = 3'd4,
    ST_NO_GLOBALS         = 3'd5,
    ST_TOO_SHORT          = 3'd6,
    ST_OFFSET_UNSUPPORTED = 3'd7
  } afra_status_t;

  // Box tag "afra", first character first.
  localparam logic [7:0] TAG_BYTES [4] = '{8'h61, 8'h66, 8'h72, 8'h61};

  // Flag byte bits
  localparam int unsigned FLAG_GLOBALS  = 5;  // 0x20
  localparam int unsigned FLAG_LONG_OFS = 6;  // 0x40
  localparam int unsigned FLAG_LONG_IDS = 7;  // 0x80

  // Header byte positions
  localparam int unsigned POS_SIZE_END    = 4;
  localparam int unsigned POS_TAG_END     = 8;
  localparam int unsigned POS_FLAGS       = 12;
  localparam int unsigned POS_LARGE_LAST  = 15;
  localparam int unsigned POS_LARGE_END   = 16;
  localparam int unsigned POS_LCOUNT      = 17;
  localparam int unsigned POS_LCOUNT_LAST = 20;
  localparam int unsigned POS_TABLES      = 21;

  // Register map
  localparam logic REG_TARGET_FRAGMENT = 1'b0;

endpackage

// ===== sv/afra_idx_if.sv =====
// Byte request channel into the fragment-index lookup block.
// Depends on nothing; valid/ready handshake with the byte and last flag.
interface afra_idx_if;
  logic       valid;
  logic       ready;
  logic [7:0] index_byte;
  logic       is_last;

  modport source (output valid, index_byte, is_last, input ready);
  modport sink (input valid, index_byte, is_last, output ready);
endinterface

// ===== sv/afra_res_if.sv =====
// Result channel out of the fragment-index lookup block.
// Depends on afra_pkg for the status type.
interface afra_res_if import afra_pkg::*; ;
  logic         valid;
  logic         ready;
  afra_status_t status;
  logic [63:0]  fragment_offset;

  modport source (output valid, status, fragment_offset, input ready);
  modport sink (input valid, status, fragment_offset, output ready);
endinterface

// ===== sv/afra_index_fragment_lookup.sv =====
// Fragment-index lookup: streamed afra box parser and global table search.
// Depends on afra_pkg, afra_idx_if, afra_res_if and the assertion macro header.
//
//   channel  dir  handshake        payload
//   idx      in   valid/ready      index_byte[7:0], is_last
//   res      out  valid/ready      status[2:0], fragment_offset[63:0]
//   apb      in   psel/penable     paddr[2:0], pwdata[31:0] (target_fragment at 0x0)
//
// One byte per cycle unless a last byte waits on a stalled result: a byte sits
// in the input register, then the parse state and, on the last byte, the result
// register are updated, so a result is valid once its last byte has left the input register.
// Reset clears the parse state and sets target_fragment to 1; no clearing pass.
// A stalled result only holds back a last byte waiting behind it; other bytes
// keep flowing while the result waits.
`include "afra_index_fragment_lookup_assert.svh"

module afra_index_fragment_lookup import afra_pkg::*; #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  afra_idx_if.sink    idx,
  afra_res_if.source  res
);

  typedef logic [POSITION_BITS-1:0] pos_t;

  // Table phase of the parse
  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LOCAL,
    PH_GCOUNT,
    PH_GLOBAL,
    PH_DONE
  } phase_t;

  localparam pos_t P_SIZE_END    = POSITION_BITS'(POS_SIZE_END);
  localparam pos_t P_TAG_END     = POSITION_BITS'(POS_TAG_END);
  localparam pos_t P_FLAGS       = POSITION_BITS'(POS_FLAGS);
  localparam pos_t P_LARGE_LAST  = POSITION_BITS'(POS_LARGE_LAST);
  localparam pos_t P_LARGE_END   = POSITION_BITS'(POS_LARGE_END);
  localparam pos_t P_LCOUNT      = POSITION_BITS'(POS_LCOUNT);
  localparam pos_t P_LCOUNT_LAST = POSITION_BITS'(POS_LCOUNT_LAST);
  localparam pos_t P_TABLES      = POSITION_BITS'(POS_TABLES);
  localparam pos_t P_MAX         = '1;

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic [31:0] target_fragment;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TARGET_FRAGMENT) ? target_fragment : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_fragment <= 32'd1;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_TARGET_FRAGMENT) begin
      target_fragment <= pwdata;
    end
  end

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       out_free;
  logic       s1_adv;

  // A last byte needs the result register; any other byte moves on at once.
  assign out_free  = !res.valid || res.ready;
  assign s1_adv    = s1_valid && (!s1_last || out_free);
  assign idx.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (idx.ready) begin
      s1_valid <= idx.valid;
    end
    if (idx.valid && idx.ready) begin
      s1_byte <= idx.index_byte;
      s1_last <= idx.is_last;
    end
  end

  // ---------------------------------------------------------------------
  // Parse state
  // ---------------------------------------------------------------------
  pos_t        byte_position,          byte_position_next;
  logic [63:0] declared_box_size,      declared_box_size_next;
  logic [7:0]  flag_byte,              flag_byte_next;
  logic        tag_ok,                 tag_ok_next;
  logic [31:0] local_entries_left,     local_entries_left_next;
  logic [31:0] global_entries_left,    global_entries_left_next;
  logic [63:0] field_shift,            field_shift_next;
  logic [4:0]  entry_byte_index,       entry_byte_index_next;
  logic [31:0] entry_segment,          entry_segment_next;
  logic [31:0] entry_fragment,         entry_fragment_next;
  logic        match_found,            match_found_next;
  logic [63:0] found_offset,           found_offset_next;
  logic [63:0] found_offset_from_afra, found_offset_from_afra_next;
  phase_t      phase,                  phase_next;

  logic [63:0] shifted;
  logic [4:0]  ebi_inc;
  logic [4:0]  id_size, ofs_size;
  logic [4:0]  seg_end, frag_end, ofs_end, entry_end;
  logic [4:0]  local_size;
  logic        cand;

  always_comb begin
    byte_position_next          = byte_position;
    declared_box_size_next      = declared_box_size;
    flag_byte_next              = flag_byte;
    tag_ok_next                 = tag_ok;
    local_entries_left_next     = local_entries_left;
    global_entries_left_next    = global_entries_left;
    field_shift_next            = field_shift;
    entry_byte_index_next       = entry_byte_index;
    entry_segment_next          = entry_segment;
    entry_fragment_next         = entry_fragment;
    match_found_next            = match_found;
    found_offset_next           = found_offset;
    found_offset_from_afra_next = found_offset_from_afra;
    phase_next                  = phase;

    shifted = {field_shift[55:0], s1_byte};
    ebi_inc = entry_byte_index + 5'd1;

    // Global entry layout: time(8), segment, fragment, offset, offset-from-afra
    id_size    = flag_byte[FLAG_LONG_IDS] ? 5'd4 : 5'd2;
    ofs_size   = flag_byte[FLAG_LONG_OFS] ? 5'd8 : 5'd4;
    seg_end    = 5'd7 + id_size;
    frag_end   = seg_end + id_size;
    ofs_end    = frag_end + ofs_size;
    entry_end  = ofs_end + ofs_size;
    local_size = flag_byte[FLAG_LONG_OFS] ? 5'd16 : 5'd12;
    cand = !match_found && entry_segment == 32'd1 && entry_fragment == target_fragment;

    // Box size, 32-bit field
    if (byte_position < P_SIZE_END) begin
      declared_box_size_next = {32'd0, declared_box_size[23:0], s1_byte};
    end
    // Tag check
    if (byte_position >= P_SIZE_END && byte_position < P_TAG_END &&
        s1_byte != TAG_BYTES[byte_position[1:0]]) begin
      tag_ok_next = 1'b0;
    end
    // Large size bytes; taken only when the short size is 1
    if (byte_position >= P_TAG_END && byte_position < P_LARGE_END) begin
      field_shift_next = shifted;
      if (byte_position == P_LARGE_LAST) begin
        if (declared_box_size == 64'd1) begin
          declared_box_size_next = shifted;
        end
        field_shift_next = '0;
      end
    end
    if (byte_position == P_FLAGS) begin
      flag_byte_next = s1_byte;
    end

    if (byte_position >= P_LCOUNT && byte_position < P_TABLES) begin
      local_entries_left_next = {local_entries_left[23:0], s1_byte};
      if (byte_position == P_LCOUNT_LAST) begin
        phase_next = (local_entries_left_next != 32'd0) ? PH_LOCAL : PH_GCOUNT;
        entry_byte_index_next = '0;
      end
    end else if (byte_position >= P_TABLES) begin
      case (phase)
        PH_LOCAL: begin
          entry_byte_index_next = ebi_inc;
          if (ebi_inc >= local_size) begin
            entry_byte_index_next   = '0;
            local_entries_left_next = local_entries_left - 32'd1;
            if (local_entries_left == 32'd1) begin
              phase_next = PH_GCOUNT;
            end
          end
        end
        PH_GCOUNT: begin
          global_entries_left_next = {global_entries_left[23:0], s1_byte};
          entry_byte_index_next    = ebi_inc;
          if (ebi_inc >= 5'd4) begin
            entry_byte_index_next = '0;
            phase_next = (global_entries_left_next != 32'd0) ? PH_GLOBAL : PH_DONE;
          end
        end
        PH_GLOBAL: begin
          field_shift_next      = shifted;
          entry_byte_index_next = ebi_inc;
          if (entry_byte_index == 5'd7) begin
            field_shift_next = '0;
          end else if (entry_byte_index == seg_end) begin
            entry_segment_next = shifted[31:0];
            field_shift_next   = '0;
          end else if (entry_byte_index == frag_end) begin
            entry_fragment_next = shifted[31:0];
            field_shift_next    = '0;
          end else if (entry_byte_index == ofs_end) begin
            if (cand) begin
              found_offset_next = shifted;
            end
            field_shift_next = '0;
          end else if (entry_byte_index >= entry_end) begin
            if (cand) begin
              found_offset_from_afra_next = shifted;
              match_found_next            = 1'b1;
            end
            field_shift_next         = '0;
            entry_byte_index_next    = '0;
            global_entries_left_next = global_entries_left - 32'd1;
            if (global_entries_left == 32'd1) begin
              phase_next = PH_DONE;
            end
          end
        end
        default: begin
          // header or done: trailing bytes are ignored
        end
      endcase
    end

    // Saturating byte count
    byte_position_next = (byte_position != P_MAX) ? byte_position + pos_t'(1) : P_MAX;
  end

  // ---------------------------------------------------------------------
  // Final verdict, from the state after the last byte
  // ---------------------------------------------------------------------
  afra_status_t status_next;
  logic [63:0]  size_eff;
  logic [2:0]   short_gap;

  always_comb begin
    // Cut-off large size: missing low bytes count as zero.
    short_gap = 3'(5'd16 - {1'b0, byte_position_next[3:0]});
    size_eff  = declared_box_size_next;
    if (byte_position_next < P_LARGE_END && declared_box_size_next == 64'd1) begin
      size_eff = (byte_position_next <= P_TAG_END) ? 64'd0 :
                 (field_shift_next << {short_gap, 3'b000});
    end

    if (byte_position_next < P_TAG_END) begin
      status_next = ST_SHORT_HEADER;
    end else if (!tag_ok_next) begin
      status_next = ST_BAD_TAG;
    end else if (size_eff != 64'(byte_position_next)) begin
      status_next = ST_SIZE_MISMATCH;
    end else if (!flag_byte_next[FLAG_GLOBALS]) begin
      status_next = ST_NO_GLOBALS;
    end else if (phase_next != PH_DONE) begin
      status_next = ST_TOO_SHORT;
    end else if (!match_found_next) begin
      status_next = ST_NOT_FOUND;
    end else if (found_offset_from_afra_next != 64'd0) begin
      status_next = ST_OFFSET_UNSUPPORTED;
    end else begin
      status_next = ST_FOUND;
    end
  end

  // ---------------------------------------------------------------------
  // State and result registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst || (s1_adv && s1_last)) begin
      byte_position          <= '0;
      declared_box_size      <= '0;
      flag_byte              <= '0;
      tag_ok                 <= 1'b1;
      local_entries_left     <= '0;
      global_entries_left    <= '0;
      field_shift            <= '0;
      entry_byte_index       <= '0;
      entry_segment          <= '0;
      entry_fragment         <= '0;
      match_found            <= 1'b0;
      found_offset           <= '0;
      found_offset_from_afra <= '0;
      phase                  <= PH_HEADER;
    end else if (s1_adv) begin
      byte_position          <= byte_position_next;
      declared_box_size      <= declared_box_size_next;
      flag_byte              <= flag_byte_next;
      tag_ok                 <= tag_ok_next;
      local_entries_left     <= local_entries_left_next;
      global_entries_left    <= global_entries_left_next;
      field_shift            <= field_shift_next;
      entry_byte_index       <= entry_byte_index_next;
      entry_segment          <= entry_segment_next;
      entry_fragment         <= entry_fragment_next;
      match_found            <= match_found_next;
      found_offset           <= found_offset_next;
      found_offset_from_afra <= found_offset_from_afra_next;
      phase                  <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
    if (s1_adv && s1_last) begin
      res.status          <= status_next;
      res.fragment_offset <= (status_next == ST_FOUND) ? found_offset_next : 64'd0;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `AFRA_ASSERT_NEXT(a_clear_after_result, s1_adv && s1_last,
                    byte_position == '0 && phase == PH_HEADER,
                    "parse state not cleared after a result")
  `AFRA_ASSERT_IMPL(a_offset_only_found, res.valid && res.status != ST_FOUND,
                    res.fragment_offset == 64'd0,
                    "offset reported without a match")
  `AFRA_ASSERT_IMPL(a_phase_after_header, phase != PH_HEADER,
                    byte_position >= P_TABLES,
                    "table phase entered before the local count")
  `AFRA_ASSERT_IMPL(a_stall_cause, !idx.ready,
                    s1_valid && s1_last && res.valid && !res.ready,
                    "input stalled without a blocked result")

endmodule
